// File: rtl/lau_pkg.sv
// Package for the linear audio upsampler: sample types, register indexes,
// ratio codes and the small arithmetic helpers. Depends on nothing.
package lau_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned MaxRun      = 8;
  localparam int unsigned MaxFactor   = 4;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 2;

  typedef logic [SampleWidth-1:0]        sample_t;
  typedef logic signed [SampleWidth-1:0] value_t;
  typedef logic [$clog2(MaxRun+1)-1:0]   count_t;
  typedef logic [$clog2(MaxFactor+1)-1:0] factor_t;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxWidth-1:0] RegUpsampleMode = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegSourceWide   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegDestWide     = 2'd2;

  // Rate ratio codes.
  typedef enum logic [1:0] {
    MODE_1X  = 2'd0,
    MODE_2X  = 2'd1,
    MODE_4X  = 2'd2,
    MODE_RSV = 2'd3
  } mode_t;

  localparam logic [7:0] NarrowOffset = 8'h80;

  // Number of results in one interpolated run for a given mode.
  function automatic factor_t factor_of(input mode_t mode);
    factor_t f;
    case (mode)
      MODE_2X: f = factor_t'(2);
      MODE_4X: f = factor_t'(4);
      default: f = factor_t'(1);
    endcase
    return f;
  endfunction

  // Raw sample bits interpreted in the output domain.
  function automatic value_t sample_value(input sample_t raw, input logic src_wide,
                                          input logic dst_wide);
    value_t v;
    if (src_wide) begin
      v = value_t'(raw);
    end else if (dst_wide) begin
      v = value_t'({raw[7:0] ^ NarrowOffset, 8'h00});
    end else begin
      v = value_t'({8'h00, raw[7:0]});
    end
    return v;
  endfunction

  // Floor of the mean of two values: arithmetic shift of the widened sum.
  function automatic value_t avg2(input value_t a, input value_t b);
    logic signed [SampleWidth:0] s;
    s = {a[SampleWidth-1], a} + {b[SampleWidth-1], b};
    return value_t'(s >>> 1);
  endfunction

endpackage

// File: rtl/lau_in_if.sv
// Request channel of the linear audio upsampler: valid/ready, one sample and a last flag.
// Depends on lau_pkg for the sample type.
interface lau_in_if import lau_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

// File: rtl/lau_out_if.sv
// Result channel of the linear audio upsampler: valid/ready, a sample and the
// run and stream end flags. Depends on lau_pkg for the sample type.
interface lau_out_if import lau_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    run_end;
  logic    stream_end;

  modport source (output valid, output sample_out, output run_end, output stream_end,
                  input ready);
  modport sink   (input valid, input sample_out, input run_end, input stream_end,
                  output ready);
endinterface

// File: rtl/linear_audio_upsampler_core.sv
// Linear audio upsampler core. Each request carries one sample, either an unsigned
// byte or a signed 16-bit word, and is taken into an input register whenever that
// register is empty or about to hand its contents on, so requests may arrive in
// consecutive cycles. From the input register one short stage of logic builds the
// whole result run (up to eight samples) and loads it into an output shift register
// that drains one result per cycle while the receiver is ready. A request that
// continues a stream yields one, two or four results for 1x, 2x and 4x, and twice
// that when it is also marked last. The first request of a stream yields none,
// unless it is also marked last, in which case it yields only the one, two or four
// copies of itself. The sustained rate is therefore set by the output shift
// register, which takes a new run only when empty or as the last result of its run leaves.
// Depends on lau_pkg, lau_in_if and lau_out_if.
module linear_audio_upsampler_core
  import lau_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  lau_in_if.sink                  in_ch,
  lau_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  // Config registers. Writes must arrive only while the block is idle; the user's duty.
  mode_t mode_r;
  logic  src_wide_r;
  logic  dst_wide_r;

  // Stream state: the raw bits of the previous request and whether one is held.
  sample_t prev_r;
  logic    have_prev_r;

  // Input register: the request together with everything needed to build its
  // run, so the configuration and the stream state are captured at acceptance.
  logic    a_valid_r;
  sample_t a_raw_r;
  logic    a_last_r;
  sample_t a_prev_r;
  logic    a_have_r;
  mode_t   a_mode_r;
  logic    a_src_r;
  logic    a_dst_r;

  // Output shift register: the pending results, head at index zero.
  logic    b_valid_r;
  sample_t run_r [MaxRun];
  count_t  rem_r;
  logic    b_last_r;

  logic    in_fire;
  logic    out_fire;
  logic    b_free;
  logic    a_move;

  value_t  p_val;
  value_t  c_val;
  value_t  mid_val;
  value_t  lead [MaxFactor];
  sample_t run_nxt [MaxRun];
  factor_t fac;
  count_t  cnt_nxt;

  // The output stage can take a new run when empty or when its final result
  // leaves in this cycle; the input stage moves on under the same condition.
  assign out_fire = out_ch.valid && out_ch.ready;
  assign b_free   = !b_valid_r || (out_fire && (rem_r == count_t'(1)));
  assign a_move   = a_valid_r && b_free;
  assign in_ch.ready = !a_valid_r || a_move;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = b_valid_r;
  assign out_ch.sample_out = run_r[0];
  assign out_ch.run_end    = rem_r == count_t'(1);
  assign out_ch.stream_end = b_last_r && (rem_r == count_t'(1));

  // Run construction. The lead part interpolates from the previous sample
  // toward the current one; any further entries are copies of the current
  // sample, which is exactly the tail that a last request appends.
  always_comb begin
    fac     = factor_of(a_mode_r);
    p_val   = sample_value(a_prev_r, a_src_r, a_dst_r);
    c_val   = sample_value(a_raw_r, a_src_r, a_dst_r);
    mid_val = avg2(p_val, c_val);
    lead[0] = p_val;
    if (a_mode_r == MODE_4X) begin
      lead[1] = avg2(p_val, mid_val);
      lead[2] = mid_val;
      lead[3] = avg2(mid_val, c_val);
    end else begin
      lead[1] = mid_val;
      lead[2] = mid_val;
      lead[3] = mid_val;
    end
    for (int k = 0; k < MaxRun; k++) begin
      if (a_have_r && (k < int'(fac))) begin
        run_nxt[k] = sample_t'(lead[k % MaxFactor]);
      end else begin
        run_nxt[k] = sample_t'(c_val);
      end
    end
    cnt_nxt = (a_have_r ? count_t'(fac) : count_t'(0)) +
              (a_last_r ? count_t'(fac) : count_t'(0));
  end

  // Configuration and stream state. A wide source forces wide results, and
  // that forcing sticks in the destination register once a request is seen.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_1X;
      src_wide_r  <= 1'b0;
      dst_wide_r  <= 1'b1;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegUpsampleMode: mode_r     <= mode_t'(cfg_data[1:0]);
          RegSourceWide:   src_wide_r <= cfg_data[0];
          RegDestWide:     dst_wide_r <= cfg_data[0];
          default: ;
        endcase
      end else if (in_fire && src_wide_r) begin
        dst_wide_r <= 1'b1;
      end
      if (in_fire) begin
        prev_r      <= in_ch.sample_in;
        have_prev_r <= !in_ch.last_in;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_raw_r  <= in_ch.sample_in;
      a_last_r <= in_ch.last_in;
      a_prev_r <= prev_r;
      a_have_r <= have_prev_r;
      a_mode_r <= mode_r;
      a_src_r  <= src_wide_r;
      a_dst_r  <= dst_wide_r | src_wide_r;
    end
  end

  // Output shift register. A request that yields no result leaves it empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      rem_r     <= '0;
      b_last_r  <= 1'b0;
    end else if (a_move) begin
      b_valid_r <= cnt_nxt != count_t'(0);
      rem_r     <= cnt_nxt;
      b_last_r  <= a_last_r;
    end else if (b_free) begin
      b_valid_r <= 1'b0;
      rem_r     <= '0;
    end else if (out_fire) begin
      rem_r <= rem_r - count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      for (int k = 0; k < MaxRun; k++) begin
        run_r[k] <= run_nxt[k];
      end
    end else if (out_fire) begin
      for (int k = 0; k < MaxRun - 1; k++) begin
        run_r[k] <= run_r[k+1];
      end
    end
  end

  // A held result always has at least one and at most eight entries left to deliver.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (rem_r != count_t'(0)) && (rem_r <= count_t'(MaxRun)))
    else $error("result pending with an empty or overfull run");

  // The stream end flag only ever marks the end of a run.
  a_stream_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.stream_end |-> out_ch.run_end)
    else $error("stream end outside the end of a run");

  // A last request closes the stream, so the next request starts afresh.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.last_in |=> !have_prev_r)
    else $error("stream state kept after a last request");

  // A blocked input register keeps its request.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_free |=> a_valid_r && $stable(a_raw_r))
    else $error("input register lost a stalled request");

endmodule

// File: sim/tb_linear_audio_upsampler_core.sv
// Self-checking testbench for linear_audio_upsampler_core: random requests and
// result stalls, with an in-bench interpolation predictor checking every result.
// Depends on lau_pkg, lau_in_if, lau_out_if and the core itself.
`timescale 1ns / 1ps

module tb_linear_audio_upsampler_core;
  import lau_pkg::*;

  // Writes to the one index past the register list must be dropped by the core.
  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;
  // Cycles with no accepted request or result before the run is abandoned.
  localparam int unsigned QuietLimit = 2000;
  // Settling time after the last expected result, ample for a request that
  // produced no result to pass through the core's input and output registers.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomRequests = 96;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    sample_t sample;
    logic    last;
  } request_t;

  typedef struct packed {
    sample_t sample;
    logic    run_end;
    logic    stream_end;
  } result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  lau_in_if  in_ch();
  lau_out_if out_ch();

  linear_audio_upsampler_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Requests waiting to be driven, and the samples the core owes us, oldest first.
  request_t pending_requests[$];
  result_t  due_samples[$];

  int unsigned n_queued;
  int unsigned n_taken;
  int unsigned n_faults;
  int unsigned quiet_cycles;
  // When set, neither side of the handshake idles.
  logic        calm;

  // Shadow of the configuration registers and of the held sample.
  mode_t   mode_m;
  logic    src_wide_m;
  logic    dst_wide_m;
  sample_t held_raw;
  logic    held_ok;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic note_fault(input string what);
    if (n_faults < MaxReports) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    n_faults++;
  endtask

  // A raw sample as a value in the output domain, under the current settings.
  // A narrow byte widened to 16 bits is re-centred on zero and moved to the top byte.
  function automatic int domain_value(input sample_t raw);
    if (src_wide_m) return int'($signed(raw));
    if (dst_wide_m) return (int'(raw[7:0]) - 128) * 256;
    return int'(raw[7:0]);
  endfunction

  // Floor of the mean; the shift on a signed int rounds towards minus infinity.
  function automatic int mean2(input int a, input int b);
    return (a + b) >>> 1;
  endfunction

  // Works out the run of results that one accepted request causes and queues it.
  // A request that opens a stream only loads the held sample, unless it is marked
  // last. A continuing request emits the interpolated run from the held sample towards
  // the new one, and any request marked last then repeats itself once per output slot.
  task automatic interpolate_request(input sample_t raw, input logic last);
    int run[$];
    int ratio;
    int p;
    int c;
    int m;
    // A wide source always gives wide output, and the core keeps it that way.
    if (src_wide_m) dst_wide_m = 1'b1;
    case (mode_m)
      MODE_2X: ratio = 2;
      MODE_4X: ratio = 4;
      default: ratio = 1;
    endcase
    c = domain_value(raw);
    if (held_ok) begin
      p = domain_value(held_raw);
      m = mean2(p, c);
      run.push_back(p);
      if (ratio == 2) begin
        run.push_back(m);
      end else if (ratio == 4) begin
        run.push_back(mean2(p, m));
        run.push_back(m);
        run.push_back(mean2(m, c));
      end
    end
    if (last) begin
      for (int i = 0; i < ratio; i++) run.push_back(c);
    end
    held_raw = raw;
    held_ok  = !last;
    foreach (run[i]) begin
      due_samples.push_back('{sample: sample_t'(run[i]),
                              run_end: (i == run.size() - 1),
                              stream_end: last && (i == run.size() - 1)});
    end
  endtask

  // Request driver: a new request is offered once the previous one is taken,
  // unless the sender chooses to idle this cycle.
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        interpolate_request(in_ch.sample_in, in_ch.last_in);
        n_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
          nxt = pending_requests.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.sample_in <= nxt.sample;
          in_ch.last_in   <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result checker: each accepted result is compared field by field with the
  // oldest outstanding one. The receiver stalls at random.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_samples.size() == 0) begin
          note_fault($sformatf("unexpected result sample=%h run_end=%b stream_end=%b",
                               out_ch.sample_out, out_ch.run_end, out_ch.stream_end));
        end else begin
          want = due_samples.pop_front();
          if (out_ch.sample_out !== want.sample || out_ch.run_end !== want.run_end ||
              out_ch.stream_end !== want.stream_end) begin
            note_fault($sformatf("expected %h/%b/%b, got %h/%b/%b",
                                 want.sample, want.run_end, want.stream_end,
                                 out_ch.sample_out, out_ch.run_end, out_ch.stream_end));
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_request(input sample_t sample, input logic last);
    pending_requests.push_back('{sample: sample, last: last});
    n_queued++;
  endtask

  // Holds the sender until every queued request is taken and every result has
  // arrived, then lets the core settle so that register writes see it idle.
  task automatic settle();
    @(posedge clk);
    while (n_taken != n_queued || due_samples.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One register write; the core takes it at the edge where cfg_we is high.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegUpsampleMode: mode_m = mode_t'(data);
      RegSourceWide:   src_wide_m = data[0];
      RegDestWide:     dst_wide_m = data[0];
      default: ;
    endcase
  endtask

  // Mostly the corners of the sample range, otherwise any bit pattern.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return {8'($urandom), 8'h80};
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned random_count;
    int unsigned streams;
    int unsigned len;
    logic        last;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.last_in   = 1'b0;
    out_ch.ready    = 1'b0;
    calm            = 1'b0;
    n_queued        = 0;
    n_taken         = 0;
    n_faults        = 0;
    quiet_cycles    = 0;
    mode_m          = MODE_1X;
    src_wide_m      = 1'b0;
    dst_wide_m      = 1'b1;
    held_raw        = '0;
    held_ok         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, 1x with narrow source widened: a single-sample stream,
    // then a stream whose middle sample has a non-zero high byte to be ignored.
    queue_request(16'h0000, 1'b1);
    queue_request(16'h00FF, 1'b0);
    queue_request(16'hAB80, 1'b0);
    queue_request(16'h0000, 1'b1);
    settle();

    // 4x with a wide source: full-scale swings and odd sums for the rounding,
    // then a single-sample stream at the most negative value.
    write_reg(RegUpsampleMode, MODE_4X);
    write_reg(RegSourceWide, 2'd1);
    queue_request(16'h7FFF, 1'b0);
    queue_request(16'h8000, 1'b0);
    queue_request(16'hFFFF, 1'b0);
    queue_request(16'h0001, 1'b1);
    queue_request(16'h8000, 1'b1);
    settle();

    // 2x with narrow bytes in and out; the destination must be rewritten since
    // the wide source above forced it wide.
    write_reg(RegUpsampleMode, MODE_2X);
    write_reg(RegSourceWide, 2'd0);
    write_reg(RegDestWide, 2'd0);
    queue_request(16'h0000, 1'b0);
    queue_request(16'h00FF, 1'b0);
    queue_request(16'hFE01, 1'b1);
    settle();

    // The reserved ratio code behaves as 1x; the upper data bit is ignored.
    write_reg(RegUpsampleMode, MODE_RSV);
    write_reg(RegDestWide, 2'd3);
    queue_request(16'h1234, 1'b0);
    queue_request(16'h00FF, 1'b1);
    settle();

    // Settings changed while a sample is held: the held raw bits are read
    // under the new settings. The unused index is written too, with no effect.
    write_reg(RegUpsampleMode, MODE_4X);
    queue_request(16'h0010, 1'b0);
    settle();
    write_reg(RegSourceWide, 2'd1);
    write_reg(RegUpsampleMode, MODE_2X);
    write_reg(RegUnused, 2'd3);
    queue_request(16'h8001, 1'b0);
    queue_request(16'h7FFE, 1'b1);
    settle();

    // 4x on narrow bytes in and out.
    write_reg(RegSourceWide, 2'd0);
    write_reg(RegDestWide, 2'd0);
    write_reg(RegUpsampleMode, MODE_4X);
    queue_request(16'h0001, 1'b0);
    queue_request(16'h0000, 1'b0);
    queue_request(16'h00FF, 1'b1);
    settle();

    // Random phases: fresh settings, then a handful of well-formed streams with
    // random content. Now and then a stream is left open across the next phase's
    // register writes, and a stray last flag cuts a stream short.
    phase = 0;
    random_count = 0;
    while (random_count < RandomRequests) begin
      phase++;
      if ($urandom_range(2) != 0) write_reg(RegUpsampleMode, 2'($urandom_range(0, 3)));
      if ($urandom_range(2) != 0) write_reg(RegSourceWide, 2'($urandom));
      if ($urandom_range(2) != 0) write_reg(RegDestWide, 2'($urandom));
      if ($urandom_range(7) == 0) write_reg(RegUnused, 2'($urandom));
      // One phase runs with no idling on either side, and it is kept long.
      calm = (phase == 2);
      streams = calm ? 4 : $urandom_range(1, 4);
      for (int s = 0; s < streams; s++) begin
        len = calm ? 6 : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          if (k == len - 1) last = ($urandom_range(5) != 0);
          else last = ($urandom_range(19) == 0);
          queue_request(pick_sample(), last);
          random_count++;
        end
      end
      settle();
    end
    calm = 1'b0;

    if (due_samples.size() != 0) begin
      note_fault($sformatf("%0d results never arrived", due_samples.size()));
    end
    if (n_faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: linear_audio_upsampler_core.f
rtl/lau_pkg.sv
rtl/lau_in_if.sv
rtl/lau_out_if.sv
rtl/linear_audio_upsampler_core.sv
sim/tb_linear_audio_upsampler_core.sv
